### rtl/core/nfd_pkg.sv
// ----------------------------------------------------------------------------
// NEC IR frame decoder package
// Shared types and timing constants for the front end, action queue and
// frame-assembly back end.
// ----------------------------------------------------------------------------
package nfd_pkg;

   // One symbol unit is this many timer ticks.
   localparam int unsigned TICKS_PER_UNIT = 375;

   // Interval boundaries in ticks, derived from unit counts.
   localparam logic [15:0] ZERO_BIT_LO   = 16'(1 * TICKS_PER_UNIT);
   localparam logic [15:0] ONE_BIT_LO    = 16'(2 * TICKS_PER_UNIT);
   localparam logic [15:0] ONE_BIT_HI    = 16'(3 * TICKS_PER_UNIT);
   localparam logic [15:0] SHORT_LIMIT   = 16'(9 * TICKS_PER_UNIT);
   localparam logic [15:0] RESTART_LO    = 16'(13 * TICKS_PER_UNIT);
   localparam logic [15:0] RESTART_HI    = 16'(14 * TICKS_PER_UNIT);
   localparam logic [15:0] LONG_LIMIT    = 16'(97 * TICKS_PER_UNIT);

   localparam logic [5:0]  COUNT_MAX       = 6'd63;
   localparam logic [5:0]  COUNT_ADDRESS   = 6'd16;
   localparam logic [5:0]  COUNT_FRAME     = 6'd32;
   localparam logic [7:0]  COMPLEMENT_MASK = 8'hff;

   localparam logic [15:0] ADDRESS_A_RESET = 16'hff00;
   localparam logic [15:0] ADDRESS_B_RESET = 16'hfd02;

   // Register indexes on the CSR port.
   localparam logic CSR_ACCEPTED_ADDRESS_A = 1'b0;
   localparam logic CSR_ACCEPTED_ADDRESS_B = 1'b1;

   // Event opcodes.
   localparam logic OP_PULSE   = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   // Action queue geometry.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ACT_HOLD   = 2'd0,
      ACT_SHIFT0 = 2'd1,
      ACT_SHIFT1 = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] pulse_interval;
   } req_payload_type;

   typedef struct packed {
      logic        frame_valid;
      logic [7:0]  command_byte;
      logic [15:0] address_code;
      logic [5:0]  bits_received;
   } rsp_payload_type;

   // Handshake between the queue head and the back end.
   typedef struct packed {
      logic       valid;
      action_type action;
   } queue_head_type;

endpackage

### rtl/core/nfd_front.sv
// ----------------------------------------------------------------------------
// NEC IR event classifier
// Turns an incoming edge interval or timeout into a single decoder action.
// ----------------------------------------------------------------------------
module nfd_front
   import nfd_pkg::*;
(
   input  logic            req_valid,
   input  req_payload_type req_payload,
   input  logic            queue_ready,
   output logic            req_ready,
   output logic            push_valid,
   output action_type      push_action
);

   logic [15:0] interval;

   assign interval   = req_payload.pulse_interval;
   assign req_ready  = queue_ready;
   assign push_valid = req_valid && queue_ready;

   // Unit windows are checked against tick bounds rather than dividing.
   always_comb begin
      if (req_payload.opcode == OP_TIMEOUT) begin
         push_action = ACT_CLEAR;
      end else if (interval >= ZERO_BIT_LO && interval < ONE_BIT_LO) begin
         push_action = ACT_SHIFT0;
      end else if (interval >= ONE_BIT_LO && interval < ONE_BIT_HI) begin
         push_action = ACT_SHIFT1;
      end else if (interval < SHORT_LIMIT || interval >= LONG_LIMIT ||
                   (interval >= RESTART_LO && interval < RESTART_HI)) begin
         push_action = ACT_CLEAR;
      end else begin
         push_action = ACT_HOLD;
      end
   end

endmodule

### rtl/core/nfd_queue.sv
// ----------------------------------------------------------------------------
// NEC IR action queue
// Small FIFO of classified actions between the front end and the back end.
// ----------------------------------------------------------------------------
module nfd_queue
   import nfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  action_type     push_action,
   output logic           queue_ready,
   output queue_head_type head,
   input  logic           pop
);

   action_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_pop;

   assign queue_ready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head.valid  = count_ff != '0;
   assign head.action = entry_ff[rd_ptr_ff];
   assign do_pop      = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_action;
      end
   end

endmodule

### rtl/core/nfd_back.sv
// ----------------------------------------------------------------------------
// NEC IR frame assembler
// Applies queued actions to the bit counter, shift register and address
// latch, checks complete frames and holds the result register.
// ----------------------------------------------------------------------------
module nfd_back
   import nfd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  queue_head_type  head,
   output logic            pop,
   input  logic [15:0]     accepted_address_a,
   input  logic [15:0]     accepted_address_b,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic [5:0]      bit_count_ff, bit_count_in;
   logic [15:0]     shift_word_ff, shift_word_in;
   logic [15:0]     latched_address_ff, latched_address_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic [5:0]      count_mid;
   logic            shifting;
   logic            frame_valid;

   // The result register frees up in the same cycle that it is taken.
   assign pop = head.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      shifting      = (head.action == ACT_SHIFT0) || (head.action == ACT_SHIFT1);
      count_mid     = bit_count_ff;
      shift_word_in = shift_word_ff;
      if (shifting) begin
         shift_word_in = {head.action == ACT_SHIFT1, shift_word_ff[15:1]};
         if (bit_count_ff != COUNT_MAX) begin
            count_mid = bit_count_ff + 1'b1;
         end
      end else if (head.action == ACT_CLEAR) begin
         count_mid = '0;
      end

      latched_address_in = latched_address_ff;
      if (count_mid == COUNT_ADDRESS) begin
         latched_address_in = shift_word_in;
      end

      // A full frame needs the command byte followed by its complement.
      bit_count_in = count_mid;
      frame_valid  = 1'b0;
      if (count_mid == COUNT_FRAME) begin
         if ((shift_word_in[7:0] ^ shift_word_in[15:8]) != COMPLEMENT_MASK) begin
            bit_count_in = '0;
         end else begin
            frame_valid = (latched_address_in == accepted_address_a) ||
                          (latched_address_in == accepted_address_b);
         end
      end

      rsp_payload_in.frame_valid   = frame_valid;
      rsp_payload_in.command_byte  = shift_word_in[7:0];
      rsp_payload_in.address_code  = latched_address_in;
      rsp_payload_in.bits_received = bit_count_in;

      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff       <= '0;
         shift_word_ff      <= '0;
         latched_address_ff <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            bit_count_ff       <= bit_count_in;
            shift_word_ff      <= shift_word_in;
            latched_address_ff <= latched_address_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### rtl/core/nec_ir_frame_decoder.sv
// ----------------------------------------------------------------------------
// NEC IR frame decoder
// Builds NEC remote frames from measured edge intervals and timeouts.
// ----------------------------------------------------------------------------
// Each request carries either an edge interval in timer ticks or a timeout.
// Every request produces exactly one response with the frame status, the
// current command byte, the latched address and the bit count.
// A classifier turns each request into an action in the same cycle it is
// accepted; a two-entry action queue feeds the assembler, which applies one
// action per cycle while the response side is not stalled and loads the
// response register. A request passes through a queue entry and then the
// response register; one request and one response transfer per cycle are
// sustained while rsp_ready stays high.
// When the response side stalls, the response register holds and the queue
// absorbs up to two further requests before req_ready drops.
// Reset clears the bit count, shift register, address latch and queue, and
// restores the accepted addresses to 0xff00 and 0xfd02. The CSR port writes
// an accepted address and should only be used while idle.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder
   import nfd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic            csr_index,
   input  logic [15:0]     csr_write_data
);

   logic           queue_ready;
   logic           push_valid;
   action_type     push_action;
   queue_head_type head;
   logic           pop;
   logic [15:0]    address_a_ff;
   logic [15:0]    address_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         address_a_ff <= ADDRESS_A_RESET;
         address_b_ff <= ADDRESS_B_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ACCEPTED_ADDRESS_A: address_a_ff <= csr_write_data;
            CSR_ACCEPTED_ADDRESS_B: address_b_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   nfd_front u_front (
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .queue_ready (queue_ready),
      .req_ready   (req_ready),
      .push_valid  (push_valid),
      .push_action (push_action)
   );

   nfd_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_action (push_action),
      .queue_ready (queue_ready),
      .head        (head),
      .pop         (pop)
   );

   nfd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .accepted_address_a (address_a_ff),
      .accepted_address_b (address_b_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_payload        (rsp_payload)
   );

   // A valid frame is only ever reported at a full 32-bit count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_valid |-> rsp_payload.bits_received == COUNT_FRAME)
      else $error("frame reported valid at a count other than 32");

   // With nothing queued, a taken response leaves the output empty.
   assert property (@(posedge clock) disable iff (reset)
      !head.valid && rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("response appeared without a queued action");

   // Every pushed action comes from a transfer on the request side.
   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> req_valid && req_ready)
      else $error("action pushed without a request transfer");

   // Every action the assembler consumes loads the response register.
   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("consumed action produced no response");

endmodule
